### design/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared constants, command/status types and the CRC-16 byte step for the
// tag frame parser.
// ----------------------------------------------------------------------------
package tfp_pkg;

    // Default block parameters
    localparam int MAX_ID_BYTES_DEF = 32;
    localparam int WINDOW_LIMIT_DEF = 1023;

    // Frame byte positions and size checks (byte position is 9 bits wide)
    localparam int POS_W = 9;
    localparam logic [POS_W-1:0] POS_LEN        = 9'd4;
    localparam logic [POS_W-1:0] POS_STATUS     = 9'd5;
    localparam logic [POS_W-1:0] POS_RSSI_HI    = 9'd6;
    localparam logic [POS_W-1:0] POS_RSSI_LO    = 9'd7;
    localparam logic [POS_W-1:0] POS_ID_LEN     = 9'd10;
    localparam logic [POS_W-1:0] POS_ID         = 9'd11;
    localparam logic [POS_W-1:0] FRAME_OVERHEAD = 9'd7;
    localparam logic [POS_W-1:0] MIN_FRAME      = 9'd12;
    localparam logic [POS_W-1:0] MAX_FRAME      = 9'd255;
    localparam logic [POS_W-1:0] ID_TAIL        = 9'd13;

    localparam logic [7:0]  HEADER_BYTE = 8'hCF;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h8408;

    // Output limit register
    localparam int          LIMIT_W     = 6;
    localparam logic [5:0]  LIMIT_RESET = 6'd12;

    // Controller to datapath commands
    typedef struct packed {
        logic take_byte;  // one received byte is transferred in
        logic rd_issue;   // read id byte k of the best tag
        logic load_out;   // load the output register, advance k
        logic clear;      // end of report: parse, best tag and index back to reset values
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic single;     // report is one result (no tag or zero length)
        logic last_k;     // id byte k is the final one of the report
    } t_dp_status;

    // Reflected CRC-16 over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### design/tfp_if.sv
// ----------------------------------------------------------------------------
// tfp_if
// Valid/ready channels of the tag frame parser: input bytes, result items
// and the output limit register write.
// ----------------------------------------------------------------------------
interface tfp_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface tfp_out_if;
    logic               valid;
    logic               ready;
    logic               tag_found;
    logic [7:0]         id_byte;
    logic [5:0]         id_length;
    logic signed [15:0] signal_strength;
    logic               last;

    modport source (output valid, output tag_found, output id_byte,
                    output id_length, output signal_strength, output last,
                    input ready);
    modport sink   (input valid, input tag_found, input id_byte,
                    input id_length, input signal_strength, input last,
                    output ready);
endinterface

interface tfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] id_output_limit;

    modport source (output valid, output id_output_limit, input ready);
    modport sink   (input valid, input id_output_limit, output ready);
endinterface

### design/tfp_ctrl.sv
// ----------------------------------------------------------------------------
// tfp_ctrl
// Controller: takes bytes while idle, then sequences the report run
// (id memory read, output register load) and the final clear.
// ----------------------------------------------------------------------------
module tfp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_action,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  tfp_pkg::t_dp_status i_status,
    output tfp_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEND
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_xfer;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (!i_in_action) begin
                        o_cmd.take_byte = 1'b1;
                    end else if (i_status.single) begin
                        n_state = S_SEND;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    if (i_status.single || i_status.last_k) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### design/tfp_datapath.sv
// ----------------------------------------------------------------------------
// tfp_datapath
// Frame parser datapath: byte counter, CRC-16, frame field capture, best tag
// selection, two-bank id memory and the output register.
// ----------------------------------------------------------------------------
module tfp_datapath #(
    parameter int MAX_ID_BYTES = tfp_pkg::MAX_ID_BYTES_DEF,
    parameter int WINDOW_LIMIT = tfp_pkg::WINDOW_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tfp_pkg::t_dp_cmd    i_cmd,
    output tfp_pkg::t_dp_status o_status,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_cfg_we,
    input  logic [5:0]          i_cfg_limit,
    output logic                o_tag_found,
    output logic [7:0]          o_id_byte,
    output logic [5:0]          o_id_length,
    output logic signed [15:0]  o_signal_strength,
    output logic                o_last
);

    localparam int POS_W = tfp_pkg::POS_W;
    localparam int IDX_W = $clog2(MAX_ID_BYTES);
    localparam int LEN_W = $clog2(MAX_ID_BYTES + 1);
    localparam int CMP_W = (LEN_W > tfp_pkg::LIMIT_W) ? LEN_W : tfp_pkg::LIMIT_W;
    localparam int WC_W  = $clog2(WINDOW_LIMIT + 1);

    // Parse state
    logic             r_in_frame, n_in_frame;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_total, n_total;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_rcv, n_rcv;
    logic [7:0]       r_status, n_status;
    logic [15:0]      r_strength, n_strength;
    logic [7:0]       r_id_len, n_id_len;
    logic [WC_W-1:0]  r_win, n_win;

    // Best tag
    logic             r_best_valid, n_best_valid;
    logic [15:0]      r_best_strength, n_best_strength;
    logic [LEN_W-1:0] r_best_len, n_best_len;
    logic             r_best_bank, n_best_bank;

    // Report
    logic [IDX_W-1:0] r_k;
    logic [5:0]       r_limit;
    logic [7:0]       r_rd_data;

    // Id memory: one bank for the best tag, the other for the frame in work
    logic [7:0]       mem [2][MAX_ID_BYTES];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;

    logic [POS_W-1:0] p;
    logic [POS_W-1:0] id_off;
    logic             frame_ok;
    logic [CMP_W-1:0] lim_ext, len_ext, n_rep;

    assign p      = r_pos;
    assign id_off = r_pos - tfp_pkg::POS_ID;

    // Byte step
    always_comb begin
        n_in_frame      = r_in_frame;
        n_pos           = r_pos;
        n_total         = r_total;
        n_crc           = r_crc;
        n_rcv           = r_rcv;
        n_status        = r_status;
        n_strength      = r_strength;
        n_id_len        = r_id_len;
        n_win           = r_win;
        n_best_valid    = r_best_valid;
        n_best_strength = r_best_strength;
        n_best_len      = r_best_len;
        n_best_bank     = r_best_bank;
        mem_we          = 1'b0;
        mem_waddr       = id_off[IDX_W-1:0];
        frame_ok        = 1'b0;
        if (i_cmd.take_byte && (r_win < WC_W'(WINDOW_LIMIT))) begin
            n_win = r_win + WC_W'(1);
            if (!r_in_frame) begin
                // Header hunt
                if (i_rx_byte == tfp_pkg::HEADER_BYTE) begin
                    n_in_frame = 1'b1;
                    n_pos      = POS_W'(1);
                    n_total    = '0;
                    n_crc      = tfp_pkg::crc_byte(tfp_pkg::CRC_INIT, i_rx_byte);
                    n_rcv      = {8'h00, i_rx_byte};
                    n_status   = '0;
                    n_strength = '0;
                    n_id_len   = '0;
                end
            end else begin
                // Field capture by position
                if (p == tfp_pkg::POS_LEN) begin
                    n_total = tfp_pkg::FRAME_OVERHEAD + POS_W'(i_rx_byte);
                end else if (p == tfp_pkg::POS_STATUS) begin
                    n_status = i_rx_byte;
                end else if (p == tfp_pkg::POS_RSSI_HI) begin
                    n_strength = {i_rx_byte, r_strength[7:0]};
                end else if (p == tfp_pkg::POS_RSSI_LO) begin
                    n_strength = {r_strength[15:8], i_rx_byte};
                end else if (p == tfp_pkg::POS_ID_LEN) begin
                    n_id_len = i_rx_byte;
                end else if ((p >= tfp_pkg::POS_ID) &&
                             (id_off < POS_W'(MAX_ID_BYTES))) begin
                    mem_we = 1'b1;
                end
                // CRC covers all but the two check bytes
                if ((p <= tfp_pkg::POS_LEN) || ((p + POS_W'(2)) < r_total)) begin
                    n_crc = tfp_pkg::crc_byte(r_crc, i_rx_byte);
                end
                n_rcv = {r_rcv[7:0], i_rx_byte};
                n_pos = p + POS_W'(1);
                // Frame end: check and keep the strongest
                if ((p >= tfp_pkg::POS_LEN) && (n_pos >= n_total)) begin
                    n_in_frame = 1'b0;
                    frame_ok = (n_total >= tfp_pkg::MIN_FRAME) &&
                               (n_total <= tfp_pkg::MAX_FRAME) &&
                               (n_status == 8'h00) && (n_crc == n_rcv) &&
                               (n_id_len != 8'h00) &&
                               (n_id_len <= 8'(MAX_ID_BYTES)) &&
                               ((POS_W'(n_id_len) + tfp_pkg::ID_TAIL) <= n_total);
                    if (frame_ok && (!r_best_valid ||
                        ($signed(n_strength) > $signed(r_best_strength)))) begin
                        n_best_valid    = 1'b1;
                        n_best_strength = n_strength;
                        n_best_len      = n_id_len[LEN_W-1:0];
                        n_best_bank     = !r_best_bank;
                    end
                end
            end
        end
    end

    // Report length and status
    assign lim_ext = CMP_W'(r_limit);
    assign len_ext = CMP_W'(r_best_len);
    assign n_rep   = (len_ext < lim_ext) ? len_ext : lim_ext;

    assign o_status.single = !r_best_valid || (n_rep == '0);
    assign o_status.last_k = ((CMP_W'(r_k) + CMP_W'(1)) == n_rep);

    // Parse and best tag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_in_frame      <= 1'b0;
            r_pos           <= '0;
            r_total         <= '0;
            r_crc           <= tfp_pkg::CRC_INIT;
            r_rcv           <= '0;
            r_status        <= '0;
            r_strength      <= '0;
            r_id_len        <= '0;
            r_win           <= '0;
            r_best_valid    <= 1'b0;
            r_best_strength <= '0;
            r_best_len      <= '0;
            r_best_bank     <= 1'b0;
        end else begin
            r_in_frame      <= n_in_frame;
            r_pos           <= n_pos;
            r_total         <= n_total;
            r_crc           <= n_crc;
            r_rcv           <= n_rcv;
            r_status        <= n_status;
            r_strength      <= n_strength;
            r_id_len        <= n_id_len;
            r_win           <= n_win;
            r_best_valid    <= n_best_valid;
            r_best_strength <= n_best_strength;
            r_best_len      <= n_best_len;
            r_best_bank     <= n_best_bank;
        end
    end

    // Report index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_k <= '0;
        end else if (i_cmd.load_out) begin
            r_k <= r_k + IDX_W'(1);
        end
    end

    // Output limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= tfp_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_limit;
        end
    end

    // Id memory: frame bytes go to the bank not holding the best tag
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[!r_best_bank][mem_waddr] <= i_rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= mem[r_best_bank][r_k];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_tag_found       <= r_best_valid;
            o_signal_strength <= r_best_strength;
            if (o_status.single) begin
                o_id_byte   <= '0;
                o_id_length <= '0;
                o_last      <= 1'b1;
            end else begin
                o_id_byte   <= r_rd_data;
                o_id_length <= n_rep[5:0];
                o_last      <= o_status.last_k;
            end
        end
    end

endmodule

### design/tag_frame_parser_best_rssi_unit.sv
// ----------------------------------------------------------------------------
// tag_frame_parser_best_rssi_unit
// Inventory reply parser that keeps the tag with the highest RSSI and reports
// its id at the end of the window.
// ----------------------------------------------------------------------------
// Usage:
//  i_in   : one transfer per reply byte (action 0) or an end-of-window marker
//           (action 1). Bytes stream at one per cycle through the byte-wide
//           CRC and frame counter while the controller is idle.
//  o_out  : end of window gives one result per reported id byte, or a single
//           result when no tag was found or the output limit is zero; last
//           marks the final one. Each id byte result is an id memory read,
//           then an output register load, and a receiver stall holds it.
//           i_in is held off during the report; the last result may sit in
//           the output register while the next window's bytes are taken.
//  i_cfg  : writes the output limit (reset 12); always ready.
//  A receiver stall holds the report at the output register. Reset, and the
//  end of every report, return the parser to header hunt with no best tag;
//  the output limit is kept across reports.
// ----------------------------------------------------------------------------
module tag_frame_parser_best_rssi_unit #(
    parameter int MAX_ID_BYTES = tfp_pkg::MAX_ID_BYTES_DEF,
    parameter int WINDOW_LIMIT = tfp_pkg::WINDOW_LIMIT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfp_in_if.sink    i_in,
    tfp_out_if.source o_out,
    tfp_cfg_if.sink   i_cfg
);

    tfp_pkg::t_dp_cmd    w_cmd;
    tfp_pkg::t_dp_status w_status;

    assign i_cfg.ready = 1'b1;

    tfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tfp_datapath #(
        .MAX_ID_BYTES (MAX_ID_BYTES),
        .WINDOW_LIMIT (WINDOW_LIMIT)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_rx_byte         (i_in.rx_byte),
        .i_cfg_we          (i_cfg.valid && i_cfg.ready),
        .i_cfg_limit       (i_cfg.id_output_limit),
        .o_tag_found       (o_out.tag_found),
        .o_id_byte         (o_out.id_byte),
        .o_id_length       (o_out.id_length),
        .o_signal_strength (o_out.signal_strength),
        .o_last            (o_out.last)
    );

    // A result load never overwrites one still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !(o_out.valid && !o_out.ready))
        else $error("output register overwritten while stalled");

    // State is cleared only together with the final result load
    a_clear_with_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |-> w_cmd.load_out)
        else $error("clear without final result");

    // End-of-window transfer starts a report and blocks further input
    a_report_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.action) |=> !i_in.ready)
        else $error("input taken during report");

    // No memory read while bytes are being taken
    a_read_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_issue |-> !i_in.ready)
        else $error("id read outside report");

endmodule
